### src/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg: shared types and constants for the gray segment compressor
// Field widths, register indexes, reset values and the bit length function.
// ----------------------------------------------------------------------------
package gsc_pkg;

	localparam int PIX_W    = 8;
	localparam int TOTAL_W  = 21;
	localparam int SEG_W    = 8;
	localparam int PBITS_W  = 4;
	localparam int HDR_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam int MAX_PIXELS_DEF   = 65536;
	localparam int WINDOW_DEPTH_DEF = 256;

	localparam logic [HDR_W-1:0]   HDR_RESET    = 5'd11;
	localparam logic [SEG_W-1:0]   MAXSEG_RESET = 8'd255;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_BITS = 2'd0,
		REG_MAX_SEGMENT = 2'd1
	} cfg_reg_t;

	// position of the highest set bit, at least 1
	function automatic logic [PBITS_W-1:0] bit_length(input logic [PIX_W-1:0] v);
		logic [PBITS_W-1:0] n;
		n = 4'd1;
		for (int b = 1; b < PIX_W; b++) begin
			if (v[b]) begin
				n = PBITS_W'(b + 1);
			end
		end
		return n;
	endfunction

endpackage

### src/grayscale_segment_compress_dp.sv
// ----------------------------------------------------------------------------
// grayscale_segment_compress_dp
// Optimal segment cost per pixel: scans the window of past widths and costs
// held in two RAMs with registered reads, one entry per cycle.
// ----------------------------------------------------------------------------
// Flow: in_stall holds off a new pixel until the result of the last one is handed on;
//   the scan tries one candidate segment length a cycle, 1 to L, through the single
//   read port of the cost and width RAMs, L = min(i, max_segment, WINDOW_DEPTH-1).
// Reset: control clears, header_bits = 11, max_segment = 255, new image.
//   No RAM clearing pass; the start-of-image cost of zero is supplied by logic.
module grayscale_segment_compress_dp #(
	parameter int MAX_PIXELS   = gsc_pkg::MAX_PIXELS_DEF,
	parameter int WINDOW_DEPTH = gsc_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gsc_pkg::PIX_W-1:0]      pixel,
	input  logic                          last_pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gsc_pkg::TOTAL_W-1:0]    total_bits,
	output logic [gsc_pkg::SEG_W-1:0]      seg_len,
	output logic [gsc_pkg::PBITS_W-1:0]    pixel_bits
);
	import gsc_pkg::*;

	localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int KW   = AW;
	localparam int CW   = $clog2(MAX_PIXELS + 1);
	localparam int MW   = (CW > KW) ? CW : KW;
	localparam int SUMW = TOTAL_W + 1;
	localparam int PW   = KW + PBITS_W;
	localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [HDR_W-1:0]     hdr_q;
	logic [SEG_W-1:0]     maxseg_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        ptr_q;
	logic [CW-1:0]        i_q;
	logic [AW-1:0]        pos_q;
	logic [PBITS_W-1:0]   bits_q;
	logic                 last_q;
	logic [KW-1:0]        lim_q;
	logic                 lim_is_i_q;
	logic [KW:0]          kr_q;
	logic [AW-1:0]        ca_q;
	logic [AW-1:0]        wa_q;
	logic                 v_s1;
	logic [KW-1:0]        k_s1;
	logic                 z_s1;
	logic                 v_s2;
	logic [KW-1:0]        k_s2;
	logic [SUMW-1:0]      c_s2;
	logic [PBITS_W-1:0]   bmax_q;
	logic [SUMW-1:0]      best_q;
	logic [KW-1:0]        len_q;
	logic                 out_valid_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [SEG_W-1:0]     seg_q;
	logic [PBITS_W-1:0]   pbits_q;

	logic [PBITS_W-1:0]   width_mem [WINDOW_DEPTH];
	logic [TOTAL_W-1:0]   cost_mem  [WINDOW_DEPTH];
	logic [PBITS_W-1:0]   wrd_s1;
	logic [TOTAL_W-1:0]   crd_s1;

	// accept-time values
	logic                 accept;
	logic                 restart;
	logic [CW-1:0]        base_cnt;
	logic [AW-1:0]        base_ptr;
	logic [CW-1:0]        i_acc;
	logic [AW-1:0]        pos_acc;
	logic [PBITS_W-1:0]   bits_acc;
	logic [SEG_W-1:0]     lim_seg;
	logic [KW-1:0]        lim_win;
	logic [KW-1:0]        lim_acc;
	logic                 lim_is_i_acc;

	// scan datapath
	logic                 issue;
	logic [PBITS_W-1:0]   w_s1;
	logic [PBITS_W-1:0]   bmax_nxt;
	logic [PW-1:0]        prod_s1;
	logic [TOTAL_W-1:0]   prev_s1;
	logic                 slot_free;
	logic                 cost_we;
	logic [TOTAL_W+1:0]   sum_tot;
	logic [TOTAL_W-1:0]   total_nxt;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign total_bits = total_q;
	assign seg_len    = seg_q;
	assign pixel_bits = pbits_q;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign restart  = (cnt_q >= CW'(MAX_PIXELS));
	assign base_cnt = restart ? '0 : cnt_q;
	assign base_ptr = restart ? '0 : ptr_q;
	assign i_acc    = base_cnt + CW'(1);
	assign pos_acc  = (base_ptr == PTR_LAST) ? '0 : base_ptr + AW'(1);
	assign bits_acc = bit_length(pixel);

	always_comb begin
		lim_seg = (maxseg_q == '0) ? SEG_W'(1) : maxseg_q;
		if ({1'b0, lim_seg} > 9'(WINDOW_DEPTH - 1)) begin
			lim_win = KW'(WINDOW_DEPTH - 1);
		end else begin
			lim_win = KW'(lim_seg);
		end
		if (MW'(i_acc) <= MW'(lim_win)) begin
			lim_acc      = KW'(i_acc);
			lim_is_i_acc = 1'b1;
		end else begin
			lim_acc      = lim_win;
			lim_is_i_acc = 1'b0;
		end
	end

	assign issue    = (state_q == ST_SCAN) && (kr_q <= {1'b0, lim_q});
	assign w_s1     = (k_s1 == KW'(1)) ? bits_q : wrd_s1;
	assign bmax_nxt = (w_s1 > bmax_q) ? w_s1 : bmax_q;
	assign prod_s1  = PW'(k_s1) * PW'(bmax_nxt);
	// start of image: cost before the first pixel is zero
	assign prev_s1  = z_s1 ? '0 : crd_s1;

	assign slot_free = !out_valid_q || !out_stall;
	assign cost_we   = (state_q == ST_DONE) && slot_free;
	assign sum_tot   = {1'b0, best_q} + (TOTAL_W + 2)'(hdr_q);
	assign total_nxt = (sum_tot > (TOTAL_W + 2)'(TOTAL_MAX)) ? TOTAL_MAX : sum_tot[TOTAL_W-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			width_mem[pos_acc] <= bits_acc;
		end
		wrd_s1 <= width_mem[wa_q];
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[pos_q] <= total_nxt;
		end
		crd_s1 <= cost_mem[ca_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hdr_q       <= HDR_RESET;
			maxseg_q    <= MAXSEG_RESET;
			cnt_q       <= '0;
			ptr_q       <= '0;
			i_q         <= '0;
			pos_q       <= '0;
			bits_q      <= '0;
			last_q      <= 1'b0;
			lim_q       <= '0;
			lim_is_i_q  <= 1'b0;
			kr_q        <= '0;
			ca_q        <= '0;
			wa_q        <= '0;
			v_s1        <= 1'b0;
			k_s1        <= '0;
			z_s1        <= 1'b0;
			v_s2        <= 1'b0;
			k_s2        <= '0;
			c_s2        <= '0;
			bmax_q      <= '0;
			best_q      <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			seg_q       <= '0;
			pbits_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_HEADER_BITS: hdr_q    <= cfg_data[HDR_W-1:0];
					REG_MAX_SEGMENT: maxseg_q <= cfg_data[SEG_W-1:0];
					default: ;
				endcase
			end

			if (cost_we) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						i_q        <= i_acc;
						pos_q      <= pos_acc;
						bits_q     <= bits_acc;
						last_q     <= last_pixel;
						lim_q      <= lim_acc;
						lim_is_i_q <= lim_is_i_acc;
						kr_q       <= (KW + 1)'(1);
						ca_q       <= base_ptr;
						wa_q       <= pos_acc;
						bmax_q     <= bits_acc;
						best_q     <= '1;
						len_q      <= KW'(1);
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one candidate length a cycle, walking back through the ring
					if (issue) begin
						kr_q <= kr_q + (KW + 1)'(1);
						ca_q <= (ca_q == '0) ? PTR_LAST : ca_q - AW'(1);
						wa_q <= ca_q;
					end
					v_s1 <= issue;
					k_s1 <= kr_q[KW-1:0];
					z_s1 <= (kr_q == {1'b0, lim_q}) && lim_is_i_q;

					if (v_s1) begin
						bmax_q <= bmax_nxt;
						c_s2   <= SUMW'(prev_s1) + SUMW'(prod_s1);
					end
					v_s2 <= v_s1;
					k_s2 <= k_s1;

					// strict compare keeps the shorter length on a tie
					if (v_s2 && (c_s2 < best_q)) begin
						best_q <= c_s2;
						len_q  <= k_s2;
					end

					if (!issue && !v_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						total_q     <= total_nxt;
						seg_q       <= SEG_W'(len_q);
						pbits_q     <= bits_q;
						cnt_q       <= last_q ? '0 : i_q;
						ptr_q       <= last_q ? '0 : pos_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
